// ===== src/smir_pkg.sv =====
package smir_pkg;

  // Field widths of the request and response items
  localparam int FUNC_W     = 3;
  localparam int SEG_ID_W   = 6;
  localparam int OFFSET_W   = 10;
  localparam int LENGTH_W   = 11;
  localparam int DATA_W     = 32;
  localparam int RESULT_W   = 32;
  localparam int STATUS_W   = 3;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_MAP       = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_UNMAP     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD      = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_STORE     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_PROG = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ID    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OFFSET   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LENGTH   = 3'd4;

endpackage

// ===== src/smir_if.sv =====
interface smir_req_if;
  logic                               valid;
  logic                               ready;
  logic [smir_pkg::FUNC_W-1:0]        func;
  logic [smir_pkg::SEG_ID_W-1:0]      seg_id;
  logic [smir_pkg::OFFSET_W-1:0]      word_offset;
  logic [smir_pkg::LENGTH_W-1:0]      seg_length;
  logic [smir_pkg::DATA_W-1:0]        write_data;

  modport source (
    output valid, func, seg_id, word_offset, seg_length, write_data,
    input  ready
  );
  modport sink (
    input  valid, func, seg_id, word_offset, seg_length, write_data,
    output ready
  );
endinterface

interface smir_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [smir_pkg::RESULT_W-1:0]      result_word;
  logic [smir_pkg::STATUS_W-1:0]      status;

  modport source (
    output valid, result_word, status,
    input  ready
  );
  modport sink (
    input  valid, result_word, status,
    output ready
  );
endinterface

// ===== src/smir_word_ram.sv =====
module smir_word_ram #(
  parameter int AW = 16,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/segmented_memory_id_recycler.sv =====
// Segmented word memory with segment id recycling.
//
// Request channel (req): func, seg_id, word_offset, seg_length, write_data.
// Response channel (rsp): result_word, status; exactly one item per request.
// Map hands out the most recently unmapped id, else the next unused id, and
// zero-fills the new segment. Unmap returns an id to the free stack. Load
// and store reach one word. Load program copies a segment over segment 0.
// One request is in flight at a time. Map writes one zero word per cycle
// into the word RAM. The segment table and the word RAM have registered
// read ports, which is why checks and loads take a step of their own.
// After reset the block runs a clearing pass over the segment table with
// req.ready low. Word RAM and free stack are not cleared; every word is
// zero-filled by map before it can be read.
// A finished response sits in the output register; a request may be
// accepted while it waits. If rsp stalls, the next response holds back
// until the register frees up.
module segmented_memory_id_recycler #(
  parameter int NUM_SEGMENTS  = 64,
  parameter int MAX_SEG_WORDS = 1024,
  parameter int WORD_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  smir_req_if.sink    req,
  smir_rsp_if.source  rsp
);

  localparam int IDW  = $clog2(NUM_SEGMENTS);
  localparam int CNTW = $clog2(NUM_SEGMENTS + 1);
  localparam int OFW  = (MAX_SEG_WORDS > 1) ? $clog2(MAX_SEG_WORDS) : 1;
  localparam int LENW = $clog2(MAX_SEG_WORDS + 1);
  localparam int AW   = IDW + OFW;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_CHECK0, S_FILL, S_COPY, S_READ, S_DONE
  } state_t;

  state_t state;

  // Latched request
  logic [smir_pkg::FUNC_W-1:0]   op;
  logic [IDW-1:0]                op_id;
  logic                          op_id_ok;
  logic [smir_pkg::OFFSET_W-1:0] op_off;
  logic [smir_pkg::LENGTH_W-1:0] op_len;
  logic [WORD_BITS-1:0]          op_data;

  // Control state
  logic [IDW-1:0]  clr;
  logic [CNTW-1:0] free_cnt;
  logic [CNTW-1:0] fresh;
  logic [IDW-1:0]  tgt_id;
  logic [LENW-1:0] cnt;
  logic [LENW-1:0] lim;

  // Pending and registered response
  logic [smir_pkg::RESULT_W-1:0] res_word;
  logic [smir_pkg::STATUS_W-1:0] res_status;
  logic                          out_valid;
  logic [smir_pkg::RESULT_W-1:0] out_word;
  logic [smir_pkg::STATUS_W-1:0] out_status;

  // Segment table: {mapped, length} per id
  logic [LENW:0]   tbl_mem [NUM_SEGMENTS];
  logic [LENW:0]   tbl_rd;
  logic [IDW-1:0]  tbl_raddr;
  logic            tbl_we;
  logic [IDW-1:0]  tbl_waddr;
  logic [LENW:0]   tbl_wdata;

  // Free id stack
  logic [IDW-1:0]  stk_mem [NUM_SEGMENTS];
  logic [IDW-1:0]  stk_rd;
  logic [IDW-1:0]  stk_raddr;
  logic            stk_we;
  logic [IDW-1:0]  stk_waddr;

  // Word RAM port
  logic                 word_we;
  logic [AW-1:0]        word_waddr;
  logic [WORD_BITS-1:0] word_wdata;
  logic [AW-1:0]        word_raddr;
  logic [WORD_BITS-1:0] word_rd;

  // Check results
  logic            live;
  logic [LENW-1:0] tbl_len;
  logic            off_bad;
  logic            too_long;
  logic            no_id;
  logic [IDW-1:0]  new_id;
  logic [LENW-1:0] cnt_prev;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.result_word = out_word;
  assign rsp.status      = out_status;

  assign tbl_len  = tbl_rd[LENW-1:0];
  assign live     = op_id_ok && tbl_rd[LENW];
  assign off_bad  = 32'(op_off) >= 32'(tbl_len);
  assign too_long = 32'(op_len) > 32'(MAX_SEG_WORDS);
  assign no_id    = (free_cnt == '0) && (fresh >= CNTW'(NUM_SEGMENTS));
  assign new_id   = (free_cnt != '0) ? stk_rd : fresh[IDW-1:0];
  assign cnt_prev = cnt - LENW'(1);

  // Read addresses: the table is read at the request id on accept, then at
  // segment 0 for load program; the stack top is read on accept.
  assign tbl_raddr = (state == S_IDLE) ? IDW'(req.seg_id) : '0;
  assign stk_raddr = IDW'(free_cnt - CNTW'(1));

  // Memory write strobes
  always_comb begin
    tbl_we     = 1'b0;
    tbl_waddr  = op_id;
    tbl_wdata  = '0;
    stk_we     = 1'b0;
    stk_waddr  = IDW'(free_cnt);
    word_we    = 1'b0;
    word_waddr = {tgt_id, cnt[OFW-1:0]};
    word_wdata = '0;
    word_raddr = {op_id, cnt[OFW-1:0]};
    unique case (state)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr;
      end
      S_CHECK: begin
        unique case (op)
          smir_pkg::FUNC_MAP: begin
            if (!too_long && !no_id) begin
              tbl_we    = 1'b1;
              tbl_waddr = new_id;
              tbl_wdata = {1'b1, LENW'(op_len)};
            end
          end
          smir_pkg::FUNC_UNMAP: begin
            if (live) begin
              tbl_we    = 1'b1;
              tbl_wdata = {1'b0, tbl_len};
              stk_we    = (free_cnt < CNTW'(NUM_SEGMENTS));
            end
          end
          smir_pkg::FUNC_STORE: begin
            if (live && !off_bad) begin
              word_we    = 1'b1;
              word_waddr = {op_id, OFW'(op_off)};
              word_wdata = op_data;
            end
          end
          smir_pkg::FUNC_LOAD: begin
            word_raddr = {op_id, OFW'(op_off)};
          end
          default: begin
          end
        endcase
      end
      S_CHECK0: begin
        if (tbl_rd[LENW]) begin
          tbl_we    = 1'b1;
          tbl_waddr = '0;
          tbl_wdata = {1'b1, lim};
        end
      end
      S_FILL: begin
        word_we = 1'b1;
      end
      S_COPY: begin
        // read word cnt of the source, write word cnt-1 into segment 0
        word_we    = (cnt != '0);
        word_waddr = {IDW'(0), cnt_prev[OFW-1:0]};
        word_wdata = word_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rd <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= op_id;
    end
    stk_rd <= stk_mem[stk_raddr];
  end

  smir_word_ram #(
    .AW (AW),
    .DW (WORD_BITS)
  ) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .raddr (word_raddr),
    .rdata (word_rd)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      free_cnt  <= '0;
      fresh     <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the taken response; S_DONE refills the register itself
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + IDW'(1);
          if (clr == IDW'(NUM_SEGMENTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op         <= req.func;
            op_id      <= IDW'(req.seg_id);
            op_id_ok   <= 32'(req.seg_id) < 32'(NUM_SEGMENTS);
            op_off     <= req.word_offset;
            op_len     <= req.seg_length;
            op_data    <= WORD_BITS'(req.write_data);
            res_word   <= '0;
            res_status <= smir_pkg::ST_OK;
            cnt        <= '0;
            if (req.func == smir_pkg::FUNC_LOAD_PROG && req.seg_id == '0) begin
              state <= S_DONE;
            end else if (req.func <= smir_pkg::FUNC_LOAD_PROG) begin
              state <= S_CHECK;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_CHECK: begin
          unique case (op)
            smir_pkg::FUNC_MAP: begin
              if (too_long) begin
                res_status <= smir_pkg::ST_LENGTH;
                state      <= S_DONE;
              end else if (no_id) begin
                res_status <= smir_pkg::ST_NO_ID;
                state      <= S_DONE;
              end else begin
                if (free_cnt != '0) begin
                  free_cnt <= free_cnt - CNTW'(1);
                end else begin
                  fresh <= fresh + CNTW'(1);
                end
                res_word <= smir_pkg::RESULT_W'(new_id);
                tgt_id   <= new_id;
                lim      <= LENW'(op_len);
                state    <= (op_len != '0) ? S_FILL : S_DONE;
              end
            end
            smir_pkg::FUNC_UNMAP: begin
              state <= S_DONE;
              if (!live) begin
                res_status <= smir_pkg::ST_UNMAPPED;
              end else if (free_cnt < CNTW'(NUM_SEGMENTS)) begin
                free_cnt <= free_cnt + CNTW'(1);
              end
            end
            smir_pkg::FUNC_LOAD, smir_pkg::FUNC_STORE: begin
              if (!live) begin
                res_status <= smir_pkg::ST_UNMAPPED;
                state      <= S_DONE;
              end else if (off_bad) begin
                res_status <= smir_pkg::ST_OFFSET;
                state      <= S_DONE;
              end else begin
                state <= (op == smir_pkg::FUNC_LOAD) ? S_READ : S_DONE;
              end
            end
            smir_pkg::FUNC_LOAD_PROG: begin
              if (!live) begin
                res_status <= smir_pkg::ST_UNMAPPED;
                state      <= S_DONE;
              end else begin
                lim   <= tbl_len;
                state <= S_CHECK0;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_CHECK0: begin
          // segment 0 entry is on the table read port now
          if (!tbl_rd[LENW]) begin
            res_status <= smir_pkg::ST_UNMAPPED;
            state      <= S_DONE;
          end else if (lim == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_COPY;
          end
        end
        S_FILL: begin
          if (cnt == lim - LENW'(1)) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + LENW'(1);
          end
        end
        S_COPY: begin
          if (cnt == lim) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + LENW'(1);
          end
        end
        S_READ: begin
          res_word <= smir_pkg::RESULT_W'(word_rd);
          state    <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_word   <= res_word;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/tb_segmented_memory_id_recycler.sv =====
`timescale 1ns / 100ps

module tb_segmented_memory_id_recycler;

  localparam int NUM_SEGMENTS  = 64;
  localparam int MAX_SEG_WORDS = 1024;
  localparam int WORD_BITS     = 32;

  // Function codes the block leaves unused; it must answer them with ok and zero.
  localparam logic [smir_pkg::FUNC_W-1:0] FUNC_RSVD_5 = 3'd5;
  localparam logic [smir_pkg::FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
  localparam logic [smir_pkg::FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

  // Longest single request is a program load of a full segment; settle for
  // longer than that at the end of the run.
  localparam int SETTLE_CYCLES = 1100;
  // Worst case would be every request a full-length map or program load,
  // with receiver stalls on top; the stimulus stays far below this.
  localparam int unsigned CYCLE_LIMIT = 5_000_000;

  localparam int IDLE_PERCENT = 8;

  typedef struct packed {
    logic [smir_pkg::FUNC_W-1:0]   func;
    logic [smir_pkg::SEG_ID_W-1:0] seg_id;
    logic [smir_pkg::OFFSET_W-1:0] word_offset;
    logic [smir_pkg::LENGTH_W-1:0] seg_length;
    logic [smir_pkg::DATA_W-1:0]   write_data;
  } seg_request_t;

  typedef struct packed {
    logic [smir_pkg::RESULT_W-1:0] result_word;
    logic [smir_pkg::STATUS_W-1:0] status;
  } seg_response_t;

  logic clk = 1'b0;
  logic rst;

  smir_req_if req ();
  smir_rsp_if rsp ();

  segmented_memory_id_recycler #(
    .NUM_SEGMENTS (NUM_SEGMENTS),
    .MAX_SEG_WORDS(MAX_SEG_WORDS),
    .WORD_BITS    (WORD_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Shadow copy of the segment memory, kept in step with each accepted item.
  logic [smir_pkg::DATA_W-1:0]   shadow_words [NUM_SEGMENTS*MAX_SEG_WORDS];
  logic [smir_pkg::LENGTH_W-1:0] shadow_lengths [NUM_SEGMENTS];
  bit                            shadow_mapped [NUM_SEGMENTS];
  logic [smir_pkg::SEG_ID_W-1:0] shadow_free_ids [NUM_SEGMENTS];
  int                            shadow_free_count;
  int                            shadow_fresh_id;

  // Responses owed by the block, oldest first.
  seg_response_t pending_responses [$];
  seg_response_t oldest_response;

  int          mismatches = 0;
  int unsigned cycle_count = 0;
  bit          steady_flow;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at %0t: %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  // Work out the response to one request and advance the shadow state.
  function automatic seg_response_t predict_response(input seg_request_t r);
    seg_response_t answer;
    int            new_id;
    int            copy_words;
    int            i;
    answer        = '0;
    answer.status = smir_pkg::ST_OK;
    case (r.func)
      smir_pkg::FUNC_MAP: begin
        // Length check wins over running out of ids.
        if (r.seg_length > MAX_SEG_WORDS) begin
          answer.status = smir_pkg::ST_LENGTH;
        end else if (shadow_free_count == 0 && shadow_fresh_id >= NUM_SEGMENTS) begin
          answer.status = smir_pkg::ST_NO_ID;
        end else begin
          // Recycle the most recently freed id before taking a fresh one.
          if (shadow_free_count != 0) begin
            shadow_free_count--;
            new_id = 32'(shadow_free_ids[shadow_free_count]);
          end else begin
            new_id = shadow_fresh_id;
            shadow_fresh_id++;
          end
          for (i = 0; i < r.seg_length; i++)
            shadow_words[new_id*MAX_SEG_WORDS + i] = '0;
          shadow_lengths[new_id] = r.seg_length;
          shadow_mapped[new_id]  = 1'b1;
          answer.result_word     = smir_pkg::RESULT_W'(new_id);
        end
      end
      smir_pkg::FUNC_UNMAP: begin
        if (!(r.seg_id < NUM_SEGMENTS && shadow_mapped[r.seg_id])) begin
          answer.status = smir_pkg::ST_UNMAPPED;
        end else begin
          shadow_mapped[r.seg_id] = 1'b0;
          if (shadow_free_count < NUM_SEGMENTS) begin
            shadow_free_ids[shadow_free_count] = r.seg_id;
            shadow_free_count++;
          end
        end
      end
      smir_pkg::FUNC_LOAD, smir_pkg::FUNC_STORE: begin
        if (!(r.seg_id < NUM_SEGMENTS && shadow_mapped[r.seg_id])) begin
          answer.status = smir_pkg::ST_UNMAPPED;
        end else if (r.word_offset >= shadow_lengths[r.seg_id]) begin
          answer.status = smir_pkg::ST_OFFSET;
        end else if (r.func == smir_pkg::FUNC_LOAD) begin
          answer.result_word = shadow_words[r.seg_id*MAX_SEG_WORDS + r.word_offset];
        end else begin
          shadow_words[r.seg_id*MAX_SEG_WORDS + r.word_offset] = r.write_data;
        end
      end
      smir_pkg::FUNC_LOAD_PROG: begin
        // Loading a program from segment zero is a no-op.
        if (r.seg_id != 0) begin
          if (!(r.seg_id < NUM_SEGMENTS && shadow_mapped[r.seg_id]) || !shadow_mapped[0]) begin
            answer.status = smir_pkg::ST_UNMAPPED;
          end else begin
            copy_words = 32'(shadow_lengths[r.seg_id]);
            if (copy_words > MAX_SEG_WORDS) copy_words = MAX_SEG_WORDS;
            for (i = 0; i < copy_words; i++)
              shadow_words[i] = shadow_words[r.seg_id*MAX_SEG_WORDS + i];
            shadow_lengths[0] = smir_pkg::LENGTH_W'(copy_words);
          end
        end
      end
      default: begin
      end
    endcase
    return answer;
  endfunction

  function automatic seg_request_t make_request(input logic [smir_pkg::FUNC_W-1:0] f,
                                                input int id, input int off, input int len,
                                                input logic [smir_pkg::DATA_W-1:0] data);
    seg_request_t r;
    r.func        = f;
    r.seg_id      = smir_pkg::SEG_ID_W'(id);
    r.word_offset = smir_pkg::OFFSET_W'(off);
    r.seg_length  = smir_pkg::LENGTH_W'(len);
    r.write_data  = data;
    return r;
  endfunction

  // Mostly well-formed traffic: live ids, offsets inside the segment and
  // short lengths, with a tenth of the items pure noise.
  function automatic seg_request_t random_request();
    seg_request_t r;
    int           live_ids [$];
    int           roll;
    int           map_cut;
    int           unmap_cut;
    int           load_cut;
    int           i;
    for (i = 0; i < NUM_SEGMENTS; i++)
      if (shadow_mapped[i]) live_ids.push_back(i);
    r.func        = smir_pkg::FUNC_W'($urandom_range(7));
    r.seg_id      = smir_pkg::SEG_ID_W'($urandom);
    r.word_offset = smir_pkg::OFFSET_W'($urandom);
    r.seg_length  = smir_pkg::LENGTH_W'($urandom);
    r.write_data  = smir_pkg::DATA_W'($urandom);
    // Lean toward map while few ids are live and toward unmap when most are.
    map_cut   = (live_ids.size() < 8) ? 35 : ((live_ids.size() > 48) ? 10 : 20);
    unmap_cut = map_cut + ((live_ids.size() > 48) ? 22 : 12);
    load_cut  = (unmap_cut + 82) / 2;
    roll      = $urandom_range(99);
    if (roll < 90) begin
      if (roll < map_cut) r.func = smir_pkg::FUNC_MAP;
      else if (roll < unmap_cut) r.func = smir_pkg::FUNC_UNMAP;
      else if (roll < load_cut) r.func = smir_pkg::FUNC_LOAD;
      else if (roll < 82) r.func = smir_pkg::FUNC_STORE;
      else r.func = smir_pkg::FUNC_LOAD_PROG;

      if (live_ids.size() != 0 && $urandom_range(99) < 85)
        r.seg_id = smir_pkg::SEG_ID_W'(live_ids[$urandom_range(live_ids.size() - 1)]);
      if (shadow_mapped[r.seg_id] && shadow_lengths[r.seg_id] != 0 && $urandom_range(99) < 85)
        r.word_offset = smir_pkg::OFFSET_W'($urandom_range(shadow_lengths[r.seg_id] - 1));

      roll = $urandom_range(99);
      if (roll < 80) r.seg_length = smir_pkg::LENGTH_W'($urandom_range(16));
      else if (roll < 92) r.seg_length = smir_pkg::LENGTH_W'($urandom_range(128, 17));
      else if (roll < 96)
        r.seg_length = smir_pkg::LENGTH_W'(MAX_SEG_WORDS - $urandom_range(3));
      else r.seg_length = smir_pkg::LENGTH_W'($urandom_range(2047));
    end
    return r;
  endfunction

  // Present one item, hold it until accepted, then log what it must produce.
  // Valid is left high afterwards so back-to-back items need no gap.
  task automatic send_request(input seg_request_t item);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.func        <= item.func;
    req.seg_id      <= item.seg_id;
    req.word_offset <= item.word_offset;
    req.seg_length  <= item.seg_length;
    req.write_data  <= item.write_data;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_responses.push_back(predict_response(item));
  endtask

  // Drop valid and hold off until every owed response has come back.
  task automatic hold_until_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  // Extremes of every field, every operation and each corner of the checks.
  task automatic test_directed_cases();
    // Program load from segment zero does nothing, even before any map.
    send_request(make_request(smir_pkg::FUNC_LOAD_PROG, 0, 0, 0, '0));
    // Requests on ids that were never mapped.
    send_request(make_request(smir_pkg::FUNC_LOAD, 5, 0, 0, '0));
    send_request(make_request(smir_pkg::FUNC_UNMAP, 63, 1023, 2047, '1));
    send_request(make_request(smir_pkg::FUNC_STORE, 63, 0, 0, 32'h1234_5678));
    send_request(make_request(smir_pkg::FUNC_LOAD_PROG, 3, 0, 0, '0));
    // Lengths just past the limit and at the top of the field.
    send_request(make_request(smir_pkg::FUNC_MAP, 0, 0, MAX_SEG_WORDS + 1, '0));
    send_request(make_request(smir_pkg::FUNC_MAP, 0, 0, 2047, '0));
    // Fresh ids in order: a short one, a full-length one and an empty one.
    send_request(make_request(smir_pkg::FUNC_MAP, 0, 0, 4, '0));
    send_request(make_request(smir_pkg::FUNC_MAP, 0, 0, MAX_SEG_WORDS, '0));
    send_request(make_request(smir_pkg::FUNC_MAP, 0, 0, 0, '0));
    send_request(make_request(smir_pkg::FUNC_STORE, 1, 1023, 0, '1));
    send_request(make_request(smir_pkg::FUNC_STORE, 1, 0, 0, '0));
    send_request(make_request(smir_pkg::FUNC_LOAD, 1, 1023, 0, '0));
    send_request(make_request(smir_pkg::FUNC_LOAD, 1, 0, 0, '0));
    // Offsets at or beyond the segment length.
    send_request(make_request(smir_pkg::FUNC_LOAD, 2, 0, 0, '0));
    send_request(make_request(smir_pkg::FUNC_STORE, 0, 4, 0, 32'hA5A5_A5A5));
    send_request(make_request(smir_pkg::FUNC_LOAD, 0, 1023, 0, '0));
    // Copy the full-length segment over segment zero and read it back.
    send_request(make_request(smir_pkg::FUNC_STORE, 0, 3, 0, 32'h5A5A_5A5A));
    send_request(make_request(smir_pkg::FUNC_LOAD_PROG, 1, 0, 0, '0));
    send_request(make_request(smir_pkg::FUNC_LOAD, 0, 1023, 0, '0));
    // Freed ids come back last in, first out.
    send_request(make_request(smir_pkg::FUNC_UNMAP, 1, 0, 0, '0));
    send_request(make_request(smir_pkg::FUNC_UNMAP, 2, 0, 0, '0));
    send_request(make_request(smir_pkg::FUNC_MAP, 0, 0, 2, '0));
    send_request(make_request(smir_pkg::FUNC_MAP, 0, 0, 3, '0));
    send_request(make_request(FUNC_RSVD_5, 1, 1, 1, '1));
    send_request(make_request(FUNC_RSVD_6, 2, 2, 2, '1));
    send_request(make_request(FUNC_RSVD_7, 3, 3, 3, '1));
    // Program load with segment zero unmapped.
    send_request(make_request(smir_pkg::FUNC_UNMAP, 0, 0, 0, '0));
    send_request(make_request(smir_pkg::FUNC_LOAD_PROG, 1, 0, 0, '0));
  endtask

  // Use up every id, hit the no-id case, then free a batch again.
  task automatic test_id_exhaustion();
    int i;
    while (shadow_free_count != 0 || shadow_fresh_id < NUM_SEGMENTS)
      send_request(make_request(smir_pkg::FUNC_MAP, $urandom, $urandom,
                                $urandom_range(8), $urandom));
    send_request(make_request(smir_pkg::FUNC_MAP, 0, 0, 1, '0));
    // Too long a length is reported ahead of the empty id pool.
    send_request(make_request(smir_pkg::FUNC_MAP, 0, 0, MAX_SEG_WORDS + 1, '0));
    send_request(make_request(smir_pkg::FUNC_MAP, 0, 0, 0, '0));
    for (i = 0; i < 16; i++)
      send_request(make_request(smir_pkg::FUNC_UNMAP, $urandom_range(NUM_SEGMENTS - 1),
                                0, 0, '0));
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_request(random_request());
  endtask

  // Check each accepted response against the oldest owed one and pick the
  // next ready at random, or hold it high during steady flow.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("response with none owed", '0, rsp.result_word);
      end else begin
        oldest_response = pending_responses.pop_front();
        if (rsp.result_word !== oldest_response.result_word)
          report_mismatch("result_word", oldest_response.result_word, rsp.result_word);
        if (rsp.status !== oldest_response.status)
          report_mismatch("status", 32'(oldest_response.status), 32'(rsp.status));
      end
    end
    rsp.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    steady_flow       = 1'b0;
    shadow_free_count = 0;
    shadow_fresh_id   = 0;
    foreach (shadow_mapped[i]) shadow_mapped[i] = 1'b0;
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.func        <= smir_pkg::FUNC_MAP;
    req.seg_id      <= '0;
    req.word_offset <= '0;
    req.seg_length  <= '0;
    req.write_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_id_exhaustion();
    // Let everything owed come back before going on.
    hold_until_drained();
    test_random_traffic(250);
    // Run a long stretch with neither side idling.
    steady_flow = 1'b1;
    test_random_traffic(200);
    steady_flow = 1'b0;
    hold_until_drained();
    test_random_traffic(250);

    // Drop valid, wait for the last responses, then settle for stragglers.
    req.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/smir_pkg.sv
src/smir_if.sv
src/smir_word_ram.sv
src/segmented_memory_id_recycler.sv
bench/tb_segmented_memory_id_recycler.sv
